>>> hw/rtl/rhmh_pkg.sv
package rhmh_pkg;

  // Heap geometry and count width
  localparam int unsigned HEAP_DEPTH = 1024;
  localparam int unsigned CITE_BITS  = 16;
  localparam int unsigned CNT_W      = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned ADDR_W     = $clog2(HEAP_DEPTH);
  localparam int unsigned POS_W      = CNT_W + 1;
  localparam int unsigned CMP_W      = (CITE_BITS > CNT_W) ? CITE_BITS : CNT_W;

  // Port widths fixed by the interface
  localparam int unsigned CITE_PORT_W = 16;
  localparam int unsigned H_PORT_W    = 11;

  // Heap memory access for the current cycle: one write and two reads
  typedef struct packed {
    logic                 we;
    logic [ADDR_W-1:0]    waddr;
    logic [CITE_BITS-1:0] wdata;
    logic [ADDR_W-1:0]    raddr_a;
    logic [ADDR_W-1:0]    raddr_b;
  } ram_req_t;

  // Result word handed to the output stage
  typedef struct packed {
    logic [CNT_W-1:0] h;
    logic             sat;
  } res_t;

  // Sequencer states
  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_UP_RD  = 9'b000000010,
    S_UP_CMP = 9'b000000100,
    S_CHK    = 9'b000001000,
    S_POP_RD = 9'b000010000,
    S_POP_LD = 9'b000100000,
    S_DN_RD  = 9'b001000000,
    S_DN_CMP = 9'b010000000,
    S_FIN    = 9'b100000000
  } state_e;

  // 1-based heap position to 0-based memory address
  function automatic logic [ADDR_W-1:0] pos2addr(input logic [POS_W-1:0] p);
    logic [POS_W-1:0] tmp;
    tmp = p - POS_W'(1);
    return tmp[ADDR_W-1:0];
  endfunction

endpackage

>>> hw/rtl/running_h_index_min_heap.sv
// Words are taken one at a time, the next back in S_IDLE after the result moves out. A count not
// above h, or with a full heap, goes straight to S_FIN, whose result loads the output register
// and raises out_valid_o. An insert climbs via S_UP_RD and S_UP_CMP per level, then checks h in
// S_CHK if the heap exceeds h; each removed minimum takes S_CHK, S_POP_RD, S_POP_LD, then S_DN_RD
// and S_DN_CMP per level (S_CHK, S_POP_RD for the last entry); levels <= log2(HEAP_DEPTH).
// Reset (rst_ni low, asynchronous) empties the heap and clears h; no clearing pass.
module running_h_index_min_heap (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [rhmh_pkg::CITE_PORT_W-1:0] citation_i,
  input  logic                             new_case_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [rhmh_pkg::H_PORT_W-1:0]    h_index_o,
  output logic                             saturated_o
);

  localparam int unsigned CITE_W = rhmh_pkg::CITE_BITS;
  localparam int unsigned H_W    = rhmh_pkg::H_PORT_W;

  logic [31:0]        cite_ext;
  logic [CITE_W-1:0]  cite;
  rhmh_pkg::ram_req_t ram_req;
  logic [CITE_W-1:0]  rdata_a, rdata_b;
  logic               res_valid, res_ready;
  rhmh_pkg::res_t     res;

  logic                          out_valid_q;
  logic [rhmh_pkg::H_PORT_W-1:0] h_index_q;
  logic                          saturated_q;

  // only the low CITE_BITS bits of a count matter
  assign cite_ext = 32'(citation_i);
  assign cite     = cite_ext[CITE_W-1:0];

  rhmh_ram #(
    .DEPTH  (rhmh_pkg::HEAP_DEPTH),
    .WIDTH  (CITE_W),
    .ADDR_W (rhmh_pkg::ADDR_W)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_req.we),
    .waddr_i   (ram_req.waddr),
    .wdata_i   (ram_req.wdata),
    .raddr_a_i (ram_req.raddr_a),
    .raddr_b_i (ram_req.raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  rhmh_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cite_i      (cite),
    .new_case_i  (new_case_i),
    .ram_o       (ram_req),
    .rdata_a_i   (rdata_a),
    .rdata_b_i   (rdata_b),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // output register: loads when empty or being drained
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      h_index_q   <= H_W'(res.h);
      saturated_q <= res.sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign h_index_o   = h_index_q;
  assign saturated_o = saturated_q;

endmodule

>>> hw/rtl/rhmh_ram.sv
module rhmh_ram #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned WIDTH  = 16,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_a_i,
  input  logic [ADDR_W-1:0] raddr_b_i,
  output logic [WIDTH-1:0]  rdata_a_o,
  output logic [WIDTH-1:0]  rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // two registered read ports
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

>>> hw/rtl/rhmh_seq.sv
module rhmh_seq (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [rhmh_pkg::CITE_BITS-1:0] cite_i,
  input  logic                           new_case_i,
  output rhmh_pkg::ram_req_t             ram_o,
  input  logic [rhmh_pkg::CITE_BITS-1:0] rdata_a_i,
  input  logic [rhmh_pkg::CITE_BITS-1:0] rdata_b_i,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output rhmh_pkg::res_t                 res_o
);

  localparam int unsigned CNT_W  = rhmh_pkg::CNT_W;
  localparam int unsigned POS_W  = rhmh_pkg::POS_W;
  localparam int unsigned CMP_W  = rhmh_pkg::CMP_W;
  localparam int unsigned CITE_W = rhmh_pkg::CITE_BITS;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(rhmh_pkg::HEAP_DEPTH);
  localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

  rhmh_pkg::state_e state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  h_q, h_d;
  logic [CNT_W-1:0]  pos_q, pos_d;
  logic [CITE_W-1:0] val_q, val_d;
  logic [CITE_W-1:0] root_q, root_d;
  logic              sat_q, sat_d;

  logic [CNT_W-1:0]  cnt_eff, h_eff;
  logic [POS_W-1:0]  pos_x, pos2, pos2p1, cnt_x;
  logic              take_r;
  logic [CITE_W-1:0] child_v;
  logic [POS_W-1:0]  child_p;

  assign cnt_eff = new_case_i ? '0 : count_q;
  assign h_eff   = new_case_i ? '0 : h_q;
  assign pos_x   = POS_W'(pos_q);
  assign pos2    = {pos_q, 1'b0};
  assign pos2p1  = {pos_q, 1'b1};
  assign cnt_x   = POS_W'(count_q);

  // smaller child, right one wins ties
  assign take_r  = (pos2p1 <= cnt_x) && (rdata_b_i <= rdata_a_i);
  assign child_v = take_r ? rdata_b_i : rdata_a_i;
  assign child_p = take_r ? pos2p1 : pos2;

  assign in_ready_o  = (state_q == rhmh_pkg::S_IDLE);
  assign res_valid_o = (state_q == rhmh_pkg::S_FIN);
  assign res_o.h     = h_q;
  assign res_o.sat   = sat_q;

  // sequencer: sift-up, pop loop, sift-down with a moving hole
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    h_d     = h_q;
    pos_d   = pos_q;
    val_d   = val_q;
    root_d  = root_q;
    sat_d   = sat_q;
    ram_o   = '0;

    unique case (state_q)
      rhmh_pkg::S_IDLE: begin
        if (in_valid_i) begin
          count_d = cnt_eff;
          h_d     = h_eff;
          sat_d   = 1'b0;
          state_d = rhmh_pkg::S_FIN;
          if (CMP_W'(cite_i) > CMP_W'(h_eff)) begin
            if (cnt_eff >= DEPTH_C) begin
              sat_d = 1'b1;
            end else begin
              count_d = cnt_eff + ONE_C;
              pos_d   = cnt_eff + ONE_C;
              val_d   = cite_i;
              state_d = rhmh_pkg::S_UP_RD;
            end
          end
        end
      end

      rhmh_pkg::S_UP_RD: begin
        if (pos_q == ONE_C) begin
          ram_o.we    = 1'b1;
          ram_o.waddr = rhmh_pkg::pos2addr(pos_x);
          ram_o.wdata = val_q;
          state_d     = (count_q > h_q) ? rhmh_pkg::S_CHK : rhmh_pkg::S_FIN;
        end else begin
          ram_o.raddr_a = rhmh_pkg::pos2addr(POS_W'(pos_q >> 1));
          state_d       = rhmh_pkg::S_UP_CMP;
        end
      end

      rhmh_pkg::S_UP_CMP: begin
        ram_o.we    = 1'b1;
        ram_o.waddr = rhmh_pkg::pos2addr(pos_x);
        if (val_q < rdata_a_i) begin
          ram_o.wdata = rdata_a_i;
          pos_d       = pos_q >> 1;
          state_d     = rhmh_pkg::S_UP_RD;
        end else begin
          ram_o.wdata = val_q;
          state_d     = (count_q > h_q) ? rhmh_pkg::S_CHK : rhmh_pkg::S_FIN;
        end
      end

      rhmh_pkg::S_CHK: begin
        if ((count_q != '0) && (CMP_W'(root_q) <= CMP_W'(h_q))) begin
          state_d = rhmh_pkg::S_POP_RD;
        end else begin
          if (count_q > h_q) begin
            h_d = count_q;
          end
          state_d = rhmh_pkg::S_FIN;
        end
      end

      rhmh_pkg::S_POP_RD: begin
        if (count_q == ONE_C) begin
          count_d = '0;
          state_d = rhmh_pkg::S_CHK;
        end else begin
          ram_o.raddr_a = rhmh_pkg::pos2addr(cnt_x);
          state_d       = rhmh_pkg::S_POP_LD;
        end
      end

      rhmh_pkg::S_POP_LD: begin
        // last entry becomes the value sifted down from the root
        val_d   = rdata_a_i;
        count_d = count_q - ONE_C;
        pos_d   = ONE_C;
        state_d = rhmh_pkg::S_DN_RD;
      end

      rhmh_pkg::S_DN_RD: begin
        if (pos2 > cnt_x) begin
          ram_o.we    = 1'b1;
          ram_o.waddr = rhmh_pkg::pos2addr(pos_x);
          ram_o.wdata = val_q;
          state_d     = rhmh_pkg::S_CHK;
        end else begin
          ram_o.raddr_a = rhmh_pkg::pos2addr(pos2);
          ram_o.raddr_b = rhmh_pkg::pos2addr(pos2p1);
          state_d       = rhmh_pkg::S_DN_CMP;
        end
      end

      rhmh_pkg::S_DN_CMP: begin
        ram_o.we    = 1'b1;
        ram_o.waddr = rhmh_pkg::pos2addr(pos_x);
        if (val_q > child_v) begin
          ram_o.wdata = child_v;
          pos_d       = child_p[CNT_W-1:0];
          state_d     = rhmh_pkg::S_DN_RD;
        end else begin
          ram_o.wdata = val_q;
          state_d     = rhmh_pkg::S_CHK;
        end
      end

      rhmh_pkg::S_FIN: begin
        if (res_ready_i) begin
          state_d = rhmh_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = rhmh_pkg::S_IDLE;
      end
    endcase

    // shadow copy of the root entry
    if (ram_o.we && (ram_o.waddr == '0)) begin
      root_d = ram_o.wdata;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rhmh_pkg::S_IDLE;
      count_q <= '0;
      h_q     <= '0;
      sat_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      h_q     <= h_d;
      sat_q   <= sat_d;
    end
  end

  // working payload
  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    val_q  <= val_d;
    root_q <= root_d;
  end

  // heap never outgrows its memory
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_C)
    else $error("heap count beyond depth");

  // between items the heap never holds more than h entries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rhmh_pkg::S_IDLE) |-> (count_q <= h_q))
    else $error("heap count above h between words");

  // hole position stays inside the heap while sifting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == rhmh_pkg::S_DN_RD) || (state_q == rhmh_pkg::S_UP_RD))
      |-> ((pos_q != '0) && (pos_q <= count_q)))
    else $error("sift position out of heap");

  // h only grows while a word is being worked on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != rhmh_pkg::S_IDLE) |=> (h_q >= $past(h_q)))
    else $error("h decreased inside a word");

endmodule
